// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/vsb_pkg.sv =====
// Package: widths, constants and handshake types for the VWAP band block.
package vsb_pkg;
  localparam int MAX_BARS = 1024;
  localparam int ADDR_W   = $clog2(MAX_BARS);
  localparam int CNT_W    = $clog2(MAX_BARS + 1);
  localparam int PRICE_W  = 24;
  localparam int VOL_W    = 20;
  localparam int SUM3_W   = 26;
  localparam int PV_W     = PRICE_W + VOL_W;
  localparam int SPV_W    = PV_W + ADDR_W;
  localparam int SV_W     = VOL_W + ADDR_W;
  localparam int SQ_W     = 2 * PRICE_W;
  localparam int PROD_W   = SQ_W + VOL_W;
  localparam int ACC_W    = PROD_W + ADDR_W;
  localparam int VAR_W    = SQ_W;
  localparam int ROOT_W   = VAR_W / 2;
  localparam int K_W      = 12;
  localparam int KPROD_W  = K_W + ROOT_W;
  localparam int KSTD_W   = KPROD_W - 8;
  localparam int UPPER_W  = 29;
  localparam int LOWER_W  = 30;
  localparam int POS_W    = 3;

  // floor(s/3) = (s * RECIP3) >> RECIP3_SH, exact for s below 2^26
  localparam int RECIP3_SH = 27;
  localparam logic [RECIP3_SH-1:0] RECIP3 = 27'd44739243;

  localparam logic [K_W-1:0] K_RESET = 12'd512;

  localparam logic [POS_W-1:0] POS_ABOVE_UPPER = 3'd0;
  localparam logic [POS_W-1:0] POS_BELOW_LOWER = 3'd1;
  localparam logic [POS_W-1:0] POS_ABOVE_VWAP  = 3'd2;
  localparam logic [POS_W-1:0] POS_BELOW_VWAP  = 3'd3;
  localparam logic [POS_W-1:0] POS_AT_VWAP     = 3'd4;
  localparam logic [POS_W-1:0] POS_MIDDLE      = 3'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;
endpackage

// ===== src/vwap_std_bands_core.sv =====
// Top level: VWAP with volume-weighted standard deviation bands.
// Input channel (in_valid_i/in_ready_o) takes one bar: high, low, close, volume,
// first and last marks. Output channel (out_valid_o/out_ready_i) gives one
// result per bar: vwap, upper and lower band, position class, series valid,
// store overflow and the echoed last mark.
// The block works on one bar at a time and is not ready while busy. It takes
// the bar, divides for the VWAP, walks the bar store through the squared
// deviation pipeline (one bar per cycle, set by the single read port),
// divides for the variance, takes the square root and forms the bands. The
// result turns valid as the block goes ready again. With a zero volume sum
// the divisions, walk and root are skipped. The result sits in an output
// register; a stalled receiver holds it, and the block may take and work on
// the next bar meanwhile, waiting only to hand over. Reset clears sums,
// count, control and sets the multiplier to 2.0; the bar store needs no
// clearing, since only entries below the count are read. The multiplier is
// written through band_multiplier_we_i; the user must write it only while
// idle, as the block itself does not enforce this.
module vwap_std_bands_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        band_multiplier_we_i,
  input  logic [vsb_pkg::K_W-1:0]     band_multiplier_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [vsb_pkg::PRICE_W-1:0] bar_high_i,
  input  logic [vsb_pkg::PRICE_W-1:0] bar_low_i,
  input  logic [vsb_pkg::PRICE_W-1:0] bar_close_i,
  input  logic [vsb_pkg::VOL_W-1:0]   bar_volume_i,
  input  logic                        first_bar_i,
  input  logic                        last_bar_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [vsb_pkg::PRICE_W-1:0] vwap_value_o,
  output logic [vsb_pkg::UPPER_W-1:0] upper_band_o,
  output logic signed [vsb_pkg::LOWER_W-1:0] lower_band_o,
  output logic [vsb_pkg::POS_W-1:0]   position_class_o,
  output logic                        series_valid_o,
  output logic                        store_overflow_o,
  output logic                        result_last_o
);
  import vsb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TP    = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_VW    = 4'd3;
  localparam logic [3:0] S_DIV1  = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_DIV2  = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_KMUL  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_q, state_d;

  logic [K_W-1:0]     k_q;
  logic [SUM3_W-1:0]  sum3_q;
  logic [PRICE_W-1:0] close_q;
  logic [VOL_W-1:0]   vol_q;
  logic               last_q, ovf_q;
  logic [SUM3_W+RECIP3_SH-1:0] tpm_q;
  logic [PRICE_W-1:0] tp;
  logic [SPV_W-1:0]   spv_q;
  logic [SV_W-1:0]    sv_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PRICE_W-1:0] vwap_q;
  logic [KPROD_W-1:0] kprod_q;
  logic [KSTD_W-1:0]  kstd;

  logic [PRICE_W-1:0] tp_mem  [MAX_BARS];
  logic [VOL_W-1:0]   vol_mem [MAX_BARS];

  // walk pipeline
  logic [CNT_W-1:0]   rd_idx_q;
  logic               issue;
  logic [3:0]         pv_q;
  logic [PRICE_W-1:0] rd_tp_q, d_q;
  logic [VOL_W-1:0]   rd_vol_q, vol1_q, vol2_q;
  logic [SQ_W-1:0]    sq_q;
  logic [PROD_W-1:0]  prod_q;
  logic [ACC_W-1:0]   acc_q;

  logic               div_start, sqrt_start;
  logic [ACC_W-1:0]   div_num;
  logic [VAR_W-1:0]   div_quo;
  logic [ROOT_W-1:0]  root;
  unit_status_t       div_st, sqrt_st;

  logic               out_valid_q;
  logic [PRICE_W-1:0] out_vwap_q;
  logic [UPPER_W-1:0] out_upper_q;
  logic signed [LOWER_W-1:0] out_lower_q;
  logic [POS_W-1:0]   out_pos_q;
  logic               out_svalid_q, out_ovf_q, out_last_q;

  logic [UPPER_W-1:0] upper;
  logic signed [LOWER_W-1:0] lower;
  logic [POS_W-1:0]   pos;
  logic               svalid;
  logic               in_acc, slot_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign tp         = tpm_q[RECIP3_SH +: PRICE_W];
  assign issue      = (state_q == S_WALK) && (rd_idx_q < cnt_q);
  assign kstd       = kprod_q[KPROD_W-1:8];

  // sequencer
  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    div_num    = ACC_W'(spv_q);
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_TP;
      S_TP:   state_d = S_ACC;
      S_ACC:  state_d = S_VW;
      S_VW: begin
        if (sv_q == '0) begin
          state_d = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV1;
        end
      end
      S_DIV1: if (div_st.done) state_d = S_WALK;
      S_WALK: begin
        if (!issue && pv_q == '0) begin
          div_start = 1'b1;
          div_num   = acc_q;
          state_d   = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_st.done) begin
          sqrt_start = 1'b1;
          state_d    = S_SQRT;
        end
      end
      S_SQRT: if (sqrt_st.done) state_d = S_KMUL;
      S_KMUL: state_d = S_OUT;
      S_OUT:  if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= K_RESET;
      spv_q    <= '0;
      sv_q     <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      pv_q     <= '0;
      rd_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (band_multiplier_we_i) k_q <= band_multiplier_i;
      if (in_acc && first_bar_i) begin
        spv_q <= '0;
        sv_q  <= '0;
        cnt_q <= '0;
      end
      if (state_q == S_ACC) begin
        ovf_q <= (cnt_q >= CNT_W'(MAX_BARS));
        if (cnt_q < CNT_W'(MAX_BARS)) begin
          spv_q <= spv_q + SPV_W'(PV_W'(tp) * PV_W'(vol_q));
          sv_q  <= sv_q + SV_W'(vol_q);
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (state_q == S_DIV1) rd_idx_q <= '0;
      else if (issue) rd_idx_q <= rd_idx_q + 1'b1;
      pv_q <= {pv_q[2:0], issue};
    end
  end

  // bar capture, tp, store, walk datapath and band multiply
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sum3_q  <= SUM3_W'(bar_high_i) + SUM3_W'(bar_low_i) + SUM3_W'(bar_close_i);
      close_q <= bar_close_i;
      vol_q   <= bar_volume_i;
      last_q  <= last_bar_i;
    end
    if (state_q == S_TP) tpm_q <= sum3_q * RECIP3;
    if (state_q == S_ACC && cnt_q < CNT_W'(MAX_BARS)) begin
      tp_mem[cnt_q[ADDR_W-1:0]]  <= tp;
      vol_mem[cnt_q[ADDR_W-1:0]] <= vol_q;
    end
    rd_tp_q  <= tp_mem[rd_idx_q[ADDR_W-1:0]];
    rd_vol_q <= vol_mem[rd_idx_q[ADDR_W-1:0]];
    d_q      <= (rd_tp_q >= vwap_q) ? rd_tp_q - vwap_q : vwap_q - rd_tp_q;
    vol1_q   <= rd_vol_q;
    sq_q     <= d_q * d_q;
    vol2_q   <= vol1_q;
    prod_q   <= sq_q * vol2_q;
    if (state_q == S_DIV1) acc_q <= '0;
    else if (pv_q[3]) acc_q <= acc_q + ACC_W'(prod_q);
    if (state_q == S_VW) begin
      vwap_q  <= close_q;
      kprod_q <= '0;
    end
    if (state_q == S_DIV1 && div_st.done) vwap_q <= div_quo[PRICE_W-1:0];
    if (state_q == S_KMUL) kprod_q <= k_q * root;
  end

  vsb_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (sv_q),
    .quo_o    (div_quo),
    .status_o (div_st)
  );

  vsb_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sqrt_start),
    .x_i      (div_quo),
    .root_o   (root),
    .status_o (sqrt_st)
  );

  // bands and class; kstd stays below 2^28, so neither band can saturate
  assign upper  = UPPER_W'(vwap_q) + UPPER_W'(kstd);
  assign lower  = $signed(LOWER_W'(vwap_q)) - $signed(LOWER_W'(kstd));
  assign svalid = !(last_q && cnt_q < CNT_W'(2));

  always_comb begin
    if (!svalid)                                     pos = POS_MIDDLE;
    else if (UPPER_W'(close_q) >= upper)             pos = POS_ABOVE_UPPER;
    else if ($signed(LOWER_W'(close_q)) <= lower)    pos = POS_BELOW_LOWER;
    else if (close_q > vwap_q)                       pos = POS_ABOVE_VWAP;
    else if (close_q < vwap_q)                       pos = POS_BELOW_VWAP;
    else                                             pos = POS_AT_VWAP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && slot_free) begin
      out_vwap_q   <= vwap_q;
      out_upper_q  <= upper;
      out_lower_q  <= lower;
      out_pos_q    <= pos;
      out_svalid_q <= svalid;
      out_ovf_q    <= ovf_q;
      out_last_q   <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign vwap_value_o     = out_vwap_q;
  assign upper_band_o     = out_upper_q;
  assign lower_band_o     = out_lower_q;
  assign position_class_o = out_pos_q;
  assign series_valid_o   = out_svalid_q;
  assign store_overflow_o = out_ovf_q;
  assign result_last_o    = out_last_q;
endmodule

// ===== src/vsb_div.sv =====
// Restoring divider, one quotient bit per cycle.
module vsb_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [vsb_pkg::ACC_W-1:0] num_i,
  input  logic [vsb_pkg::SV_W-1:0]  den_i,
  output logic [vsb_pkg::VAR_W-1:0] quo_o,
  output vsb_pkg::unit_status_t     status_o
);
  import vsb_pkg::*;

  localparam int STEP_W = $clog2(ACC_W);

  logic [ACC_W-1:0]  n_q, n_d;
  logic [SV_W-1:0]   r_q, r_d, den_q;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [SV_W:0]     trial;
  logic              fits;

  assign trial = {r_q, n_q[ACC_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    n_d    = n_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d    = num_i;
      r_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d   = {n_q[ACC_W-2:0], fits};
      r_d   = fits ? SV_W'(trial - {1'b0, den_q}) : trial[SV_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == STEP_W'(ACC_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    r_q <= r_d;
    if (start_i) den_q <= den_i;
  end

  assign quo_o         = n_q[VAR_W-1:0];
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
endmodule

// ===== src/vsb_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module vsb_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [vsb_pkg::VAR_W-1:0]  x_i,
  output logic [vsb_pkg::ROOT_W-1:0] root_o,
  output vsb_pkg::unit_status_t      status_o
);
  import vsb_pkg::*;

  localparam int REM_W  = ROOT_W + 3;
  localparam int STEP_W = $clog2(ROOT_W);

  logic [VAR_W-1:0]  x_q, x_d;
  logic [REM_W-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  assign rem_sh = {rem_q[REM_W-3:0], x_q[VAR_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = x_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = {x_q[VAR_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == STEP_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o        = root_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
endmodule

// ===== src/vsb_checker.sv =====
// Port-level checker for the VWAP band block, with its bind.
`include "assert_macros.svh"

module vsb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] position_class_o,
  input logic       series_valid_o,
  input logic       result_last_o
);
  import vsb_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `ASSERT_SAME(a_middle_iff_invalid, clk_i, rst_ni, out_valid_o,
    series_valid_o == (position_class_o != POS_MIDDLE))
  `ASSERT_SAME(a_invalid_only_last, clk_i, rst_ni, out_valid_o && !series_valid_o,
    result_last_o)
endmodule

bind vwap_std_bands_core vsb_checker u_vsb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .position_class_o (position_class_o),
  .series_valid_o   (series_valid_o),
  .result_last_o    (result_last_o)
);
